/* rtl/sbfl_pkg.sv */
// Shared types and constants of the sharded buffer free-list allocator.
package sbfl_pkg;

  localparam int SIZE_W     = 21;
  localparam int COUNT_W    = 13;
  localparam int OFFSET_W   = 32;
  localparam int REQ_W      = 8;
  localparam int JOB_IDX_W  = 13;
  localparam int REG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 21'd4096;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
  localparam logic [SIZE_W-1:0]  MIN_SIZE    = 21'd4;

  // command codes
  localparam logic CMD_REQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SIZE  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [REQ_W-1:0]    requester;
    logic [OFFSET_W-1:0] release_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] granted_offset;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                 cmd;
    logic                 bad;
    logic [REQ_W-1:0]     requester;
    logic [JOB_IDX_W-1:0] idx;
  } job_t;

endpackage

/* rtl/sbfl_queue.sv */
// Small word queue used between front and back and on the result side.
module sbfl_queue #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  T     wdata,
  output logic full,
  input  logic rd,
  output T     rdata,
  output logic empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               slots [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  cnt;
  logic           do_wr;
  logic           do_rd;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = slots[rp];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

/* rtl/sbfl_front.sv */
// Front end: takes input words, divides release offsets, emits classified jobs.
module sbfl_front #(
  parameter int CNT_W = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  sbfl_pkg::in_word_t          item,
  input  logic [sbfl_pkg::SIZE_W-1:0] esize,
  input  logic [CNT_W-1:0]            ecount,
  output logic                        busy,
  output sbfl_pkg::job_t              job,
  output logic                        job_push,
  input  logic                        job_full
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_EMIT = 3'b100
  } fstate_t;

  fstate_t                             state;
  logic                                cmd;
  logic [sbfl_pkg::REQ_W-1:0]          req;
  logic [sbfl_pkg::OFFSET_W-1:0]       quo;
  logic [sbfl_pkg::SIZE_W-1:0]         rem;
  logic [4:0]                          cnt;
  logic [sbfl_pkg::SIZE_W:0]           trial;
  logic                                ge;

  // one restoring division step
  assign trial = {rem, quo[sbfl_pkg::OFFSET_W-1]};
  assign ge    = (trial >= {1'b0, esize});

  assign busy     = (state != F_IDLE);
  assign job_push = (state == F_EMIT) && !job_full;

  always_comb begin
    job.cmd       = cmd;
    job.requester = req;
    job.idx       = quo[sbfl_pkg::JOB_IDX_W-1:0];
    job.bad       = (cmd == sbfl_pkg::CMD_RELEASE) &&
                    ((rem != '0) || (quo >= sbfl_pkg::OFFSET_W'(ecount)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (take) begin
            cmd   <= item.cmd;
            req   <= item.requester;
            quo   <= item.release_offset;
            rem   <= '0;
            cnt   <= '0;
            state <= (item.cmd == sbfl_pkg::CMD_RELEASE) ? F_DIV : F_EMIT;
          end
        end
        F_DIV: begin
          rem   <= ge ? sbfl_pkg::SIZE_W'(trial - {1'b0, esize})
                      : trial[sbfl_pkg::SIZE_W-1:0];
          quo   <= {quo[sbfl_pkg::OFFSET_W-2:0], ge};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= F_EMIT;
          end
        end
        F_EMIT: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/sbfl_back.sv */
// Back end: shard lists, per-requester caches, refill, flush, steal, results.
module sbfl_back #(
  parameter int NUM_SHARDS   = 4,
  parameter int NUM_CACHES   = 8,
  parameter int CACHE_CAP    = 32,
  parameter int REFILL_BATCH = 16,
  parameter int MAX_BUFFERS  = 4096,
  parameter int CNT_W        = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rebuild,
  input  logic [sbfl_pkg::SIZE_W-1:0] esize,
  input  logic [CNT_W-1:0]            ecount,
  input  sbfl_pkg::job_t              job,
  input  logic                        job_empty,
  output logic                        job_pop,
  output sbfl_pkg::out_word_t         res_word,
  output logic                        res_push,
  input  logic                        res_full,
  output logic                        rebuilding
);
  localparam int IW    = $clog2(MAX_BUFFERS);
  localparam int LW    = CNT_W;
  localparam int CIW   = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
  localparam int SIW   = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
  localparam int FW    = $clog2(CACHE_CAP + 1);
  localparam int BW    = $clog2(CACHE_CAP);
  localparam int AW    = $clog2(NUM_CACHES * CACHE_CAP);
  localparam int HALF  = CACHE_CAP / 2;
  localparam int HW    = $clog2(HALF + 1);
  localparam int LIMIT = (REFILL_BATCH < CACHE_CAP) ? REFILL_BATCH : CACHE_CAP;
  localparam int KW    = $clog2(NUM_CACHES + 1);
  localparam int SCW   = $clog2(NUM_SHARDS + 1);
  localparam int PW    = (IW + sbfl_pkg::SIZE_W > 32) ? IW + sbfl_pkg::SIZE_W : 32;
  localparam logic [LW-1:0] NIL = LW'(MAX_BUFFERS);

  typedef enum logic [11:0] {
    S_REBUILD     = 12'h001,
    S_IDLE        = 12'h002,
    S_REFILL      = 12'h004,
    S_REFILL_WAIT = 12'h008,
    S_STEAL       = 12'h010,
    S_POP         = 12'h020,
    S_POP_WAIT    = 12'h040,
    S_FLUSH_RD    = 12'h080,
    S_FLUSH_WAIT  = 12'h100,
    S_FLUSH_END   = 12'h200,
    S_PUSH        = 12'h400,
    S_RESULT      = 12'h800
  } bstate_t;

  // remainder of a requester slot by a small constant, eight shift-subtract steps
  function automatic logic [7:0] mod8(input logic [7:0] x, input logic [5:0] m);
    logic [13:0] r;
    logic [13:0] sh;
    r = {6'd0, x};
    for (int k = 7; k >= 0; k--) begin
      sh = 14'(m) << k;
      if (r >= sh) begin
        r = r - sh;
      end
    end
    return r[7:0];
  endfunction

  // slot position inside a cache ring
  function automatic logic [BW-1:0] wrap(input logic [BW-1:0] a, input logic [BW:0] b);
    logic [BW:0] s;
    s = {1'b0, a} + b;
    if (s >= (BW+1)'(CACHE_CAP)) begin
      s = s - (BW+1)'(CACHE_CAP);
    end
    return s[BW-1:0];
  endfunction

  function automatic logic [AW-1:0] caddr(input logic [CIW-1:0] c, input logic [BW-1:0] s);
    return AW'(c) * AW'(CACHE_CAP) + AW'(s);
  endfunction

  function automatic logic [CIW-1:0] cinc(input logic [CIW-1:0] c);
    return (c == CIW'(NUM_CACHES - 1)) ? '0 : c + CIW'(1);
  endfunction

  function automatic logic [SIW-1:0] sinc(input logic [SIW-1:0] s);
    return (s == SIW'(NUM_SHARDS - 1)) ? '0 : s + SIW'(1);
  endfunction

  bstate_t           state;
  logic [LW-1:0]     link_mem [MAX_BUFFERS];
  logic [IW-1:0]     cache_mem [NUM_CACHES * CACHE_CAP];
  logic [LW-1:0]     shard_head [NUM_SHARDS];
  logic [FW-1:0]     fill [NUM_CACHES];
  logic [BW-1:0]     base [NUM_CACHES];
  logic [IW-1:0]     ri;
  logic [CIW-1:0]    jc;
  logic [CIW-1:0]    pc;
  logic [CIW-1:0]    so;
  logic [SIW-1:0]    jh;
  logic [SIW-1:0]    sh;
  logic [SCW-1:0]    si;
  logic [KW-1:0]     k;
  logic [HW-1:0]     fi;
  logic [IW-1:0]     jidx;
  logic [IW-1:0]     first;
  logic [IW-1:0]     prev;
  logic [1:0]        res_status;
  logic [31:0]       res_off;

  logic              lwe;
  logic [IW-1:0]     lwaddr;
  logic [LW-1:0]     lwdata;
  logic [IW-1:0]     lraddr;
  logic [LW-1:0]     lrdata;
  logic              cwe;
  logic [AW-1:0]     cwaddr;
  logic [IW-1:0]     cwdata;
  logic [AW-1:0]     craddr;
  logic [IW-1:0]     crdata;

  logic [CIW-1:0]    jcache;
  logic [SIW-1:0]    jhome;
  logic              refill_done;
  logic              refill_take;
  logic [LW-1:0]     rb_link;
  logic [PW-1:0]     prod;

  assign jcache = CIW'(mod8(job.requester, 6'(NUM_CACHES)));
  assign jhome  = SIW'(mod8(job.requester, 6'(NUM_SHARDS)));

  assign refill_done = (fill[pc] == FW'(LIMIT)) || (si == SCW'(NUM_SHARDS));
  assign refill_take = !refill_done && (shard_head[sh] != NIL);

  // initial link of each index during the rebuild pass
  assign rb_link = ((32'(ri) < 32'(ecount)) &&
                    (32'(ri) + 32'(NUM_SHARDS) < 32'(ecount)))
                   ? LW'(32'(ri) + 32'(NUM_SHARDS)) : NIL;

  assign prod = PW'(crdata) * PW'(esize);

  assign rebuilding = (state == S_REBUILD);
  assign job_pop    = (state == S_IDLE) && !job_empty && !rebuild;
  assign res_push   = (state == S_RESULT) && !res_full;
  assign res_word.status         = res_status;
  assign res_word.granted_offset = res_off;

  // memory port control
  always_comb begin
    lwe    = 1'b0;
    lwaddr = ri;
    lwdata = rb_link;
    lraddr = IW'(shard_head[sh]);
    cwe    = 1'b0;
    cwaddr = caddr(jc, wrap(base[jc], (BW+1)'(fill[jc])));
    cwdata = jidx;
    craddr = caddr(pc, wrap(base[pc], (BW+1)'(fill[pc] - FW'(1))));
    case (state)
      S_REBUILD: lwe = 1'b1;
      S_REFILL: begin
        cwe    = refill_take;
        cwaddr = caddr(pc, wrap(base[pc], (BW+1)'(fill[pc])));
        cwdata = IW'(shard_head[sh]);
      end
      S_FLUSH_RD: craddr = caddr(jc, wrap(base[jc], (BW+1)'(fi)));
      S_FLUSH_WAIT: begin
        lwe    = (fi != '0);
        lwaddr = prev;
        lwdata = LW'(crdata);
      end
      S_FLUSH_END: begin
        lwe    = 1'b1;
        lwaddr = prev;
        lwdata = shard_head[jh];
      end
      S_PUSH: cwe = 1'b1;
      default: ;
    endcase
  end

  // link memory
  always_ff @(posedge clk) begin
    if (lwe) begin
      link_mem[lwaddr] <= lwdata;
    end
    lrdata <= link_mem[lraddr];
  end

  // cache entry memory
  always_ff @(posedge clk) begin
    if (cwe) begin
      cache_mem[cwaddr] <= cwdata;
    end
    crdata <= cache_mem[craddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_REBUILD;
      ri    <= '0;
    end else if (rebuild) begin
      state <= S_REBUILD;
      ri    <= '0;
    end else begin
      unique case (state)
        S_REBUILD: begin
          ri <= ri + IW'(1);
          for (int s = 0; s < NUM_SHARDS; s++) begin
            shard_head[s] <= (32'(s) < 32'(ecount)) ? LW'(s) : NIL;
          end
          for (int c = 0; c < NUM_CACHES; c++) begin
            fill[c] <= '0;
            base[c] <= '0;
          end
          if (ri == IW'(MAX_BUFFERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!job_empty) begin
            jc   <= jcache;
            pc   <= jcache;
            jh   <= jhome;
            sh   <= jhome;
            si   <= '0;
            fi   <= '0;
            jidx <= IW'(job.idx);
            if (job.cmd == sbfl_pkg::CMD_REQUIRE) begin
              state <= (fill[jcache] != '0) ? S_POP : S_REFILL;
            end else if (job.bad) begin
              res_status <= sbfl_pkg::ST_BAD;
              res_off    <= '0;
              state      <= S_RESULT;
            end else if (fill[jcache] == FW'(CACHE_CAP)) begin
              state <= S_FLUSH_RD;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_REFILL: begin
          if (refill_done) begin
            if (fill[pc] != '0) begin
              state <= S_POP;
            end else begin
              so    <= cinc(pc);
              k     <= KW'(1);
              state <= S_STEAL;
            end
          end else if (shard_head[sh] == NIL) begin
            sh <= sinc(sh);
            si <= si + SCW'(1);
          end else begin
            fill[pc] <= fill[pc] + FW'(1);
            state    <= S_REFILL_WAIT;
          end
        end
        S_REFILL_WAIT: begin
          shard_head[sh] <= lrdata;
          state          <= S_REFILL;
        end
        S_STEAL: begin
          if (k == KW'(NUM_CACHES)) begin
            res_status <= sbfl_pkg::ST_EMPTY;
            res_off    <= '0;
            state      <= S_RESULT;
          end else if (fill[so] != '0) begin
            pc    <= so;
            state <= S_POP;
          end else begin
            so <= cinc(so);
            k  <= k + KW'(1);
          end
        end
        S_POP: begin
          fill[pc] <= fill[pc] - FW'(1);
          state    <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          res_status <= sbfl_pkg::ST_OK;
          res_off    <= prod[31:0];
          state      <= S_RESULT;
        end
        S_FLUSH_RD: state <= S_FLUSH_WAIT;
        S_FLUSH_WAIT: begin
          if (fi == '0) begin
            first <= crdata;
          end
          prev <= crdata;
          fi   <= fi + HW'(1);
          state <= (fi == HW'(HALF - 1)) ? S_FLUSH_END : S_FLUSH_RD;
        end
        S_FLUSH_END: begin
          shard_head[jh] <= LW'(first);
          base[jc]       <= wrap(base[jc], (BW+1)'(HALF));
          fill[jc]       <= fill[jc] - FW'(HALF);
          state          <= S_PUSH;
        end
        S_PUSH: begin
          fill[jc]   <= fill[jc] + FW'(1);
          res_status <= sbfl_pkg::ST_OK;
          res_off    <= '0;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a refill never overfills the cache beyond the batch limit
  a_refill_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL_WAIT) |-> (fill[pc] <= FW'(LIMIT)))
    else $error("refill past batch limit");

  // a pop always finds a non-empty cache
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (fill[pc] != '0))
    else $error("pop from empty cache");

  // a flush only starts on a full cache
  a_flush_full: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FLUSH_RD) && (fi == '0)) |-> (fill[jc] == FW'(CACHE_CAP)))
    else $error("flush of a cache that is not full");

  // the rebuild pass ends after its last index
  a_rebuild_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REBUILD) && (ri == IW'(MAX_BUFFERS - 1)) && !rebuild) |=>
      (state == S_IDLE))
    else $error("rebuild pass did not end");

endmodule

/* rtl/sharded_buffer_free_list_allocator_core.sv */
// Top level of the sharded buffer free-list allocator.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | push / full        | item   : cmd, requester, release_offset
//  result    | pop / empty        | result : status, granted_offset
//  config    | cfg_write          | cfg_index, cfg_data (size, count)
//
// A require from a warm cache pops one entry; an empty cache is first refilled
// from the shards, skipping empty shards, and if that yields nothing the other
// caches are searched for one to steal from. A release passes the front-end divider,
// and a release to a full cache first flushes half of it back to its home shard.
// After reset and after each count register write the link memory is rebuilt,
// one entry a cycle, over all MAX_BUFFERS entries; full stays high meanwhile.
// Results wait in a two-word queue; when it is full the back end, and behind it the front, stall.
module sharded_buffer_free_list_allocator_core #(
  parameter int NUM_SHARDS   = 4,
  parameter int NUM_CACHES   = 8,
  parameter int CACHE_CAP    = 32,
  parameter int REFILL_BATCH = 16,
  parameter int MAX_BUFFERS  = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  sbfl_pkg::in_word_t             item,
  output logic                           empty,
  input  logic                           pop,
  output sbfl_pkg::out_word_t            result,
  input  logic                           cfg_write,
  input  logic [sbfl_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [sbfl_pkg::SIZE_W-1:0]    cfg_data
);
  localparam int LW = $clog2(MAX_BUFFERS + 1);
  localparam int XW = (LW > sbfl_pkg::COUNT_W) ? LW : sbfl_pkg::COUNT_W;

  logic [sbfl_pkg::SIZE_W-1:0]  size_reg;
  logic [sbfl_pkg::COUNT_W-1:0] count_reg;
  logic [sbfl_pkg::SIZE_W-1:0]  esize;
  logic [LW-1:0]                ecount;
  logic                         rebuild;
  logic                         front_busy;
  logic                         rebuilding;
  logic                         take;
  sbfl_pkg::job_t               fjob;
  sbfl_pkg::job_t               bjob;
  logic                         job_push;
  logic                         job_full;
  logic                         job_pop;
  logic                         job_empty;
  sbfl_pkg::out_word_t          res_word;
  logic                         res_push;
  logic                         res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg  <= sbfl_pkg::SIZE_RESET;
      count_reg <= sbfl_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sbfl_pkg::REG_SIZE:  size_reg  <= cfg_data;
        sbfl_pkg::REG_COUNT: count_reg <= cfg_data[sbfl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign rebuild = cfg_write && (cfg_index == sbfl_pkg::REG_COUNT);

  // clamped size and count
  assign esize  = (size_reg < sbfl_pkg::MIN_SIZE) ? sbfl_pkg::MIN_SIZE : size_reg;
  assign ecount = (XW'(count_reg) > XW'(MAX_BUFFERS)) ? LW'(MAX_BUFFERS)
                                                      : LW'(count_reg);

  assign full = front_busy || rebuilding;
  assign take = push && !full;

  sbfl_front #(
    .CNT_W (LW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .esize    (esize),
    .ecount   (ecount),
    .busy     (front_busy),
    .job      (fjob),
    .job_push (job_push),
    .job_full (job_full)
  );

  sbfl_queue #(
    .T     (sbfl_pkg::job_t),
    .DEPTH (sbfl_pkg::QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (fjob),
    .full  (job_full),
    .rd    (job_pop),
    .rdata (bjob),
    .empty (job_empty)
  );

  sbfl_back #(
    .NUM_SHARDS   (NUM_SHARDS),
    .NUM_CACHES   (NUM_CACHES),
    .CACHE_CAP    (CACHE_CAP),
    .REFILL_BATCH (REFILL_BATCH),
    .MAX_BUFFERS  (MAX_BUFFERS),
    .CNT_W        (LW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .rebuild    (rebuild),
    .esize      (esize),
    .ecount     (ecount),
    .job        (bjob),
    .job_empty  (job_empty),
    .job_pop    (job_pop),
    .res_word   (res_word),
    .res_push   (res_push),
    .res_full   (res_full),
    .rebuilding (rebuilding)
  );

  sbfl_queue #(
    .T     (sbfl_pkg::out_word_t),
    .DEPTH (sbfl_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_word),
    .full  (res_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
